FILE: rtl/pic_pkg.sv
// Shared types and codes of the padded image convolution block.
`timescale 1ns / 1ps

package pic_pkg;

    localparam int PIX_W      = 32;
    localparam int COEF_W     = 18;
    localparam int COEF_IDX_W = 6;
    localparam int CH_W       = 8;
    localparam int CH_NUM     = 4;

    typedef enum logic {
        KIND_COEF  = 1'b0,
        KIND_PIXEL = 1'b1
    } pic_kind_t;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_KERNEL_SIZE   = 2'd2,
        REG_CHANNEL_COUNT = 2'd3
    } pic_reg_t;

    typedef struct packed {
        logic [10:0] image_width;
        logic [12:0] image_height;
        logic [2:0]  kernel_size;
        logic [2:0]  channel_count;
    } pic_cfg_t;

    typedef struct packed {
        pic_kind_t               kind;
        logic [COEF_IDX_W-1:0]   coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic [PIX_W-1:0]        pixel;
        logic                    emit;
        logic                    last;
    } pic_item_t;

endpackage

FILE: rtl/pic_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                   wdata,
    input  logic                               re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/pic_queue.sv
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps

module pic_queue
    import pic_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pic_item_t push_item,
    output logic      not_full,
    input  logic      pop,
    output logic      not_empty,
    output pic_item_t head_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    pic_item_t       slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_next;
    logic [PW:0]     count_next;

    assign not_full  = (count_reg != (PW + 1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/pic_front.sv
// Front part: configuration registers, input transfers and frame position tracking.
`timescale 1ns / 1ps

module pic_front
    import pic_pkg::*;
#(
    parameter int KMAX             = 7,
    parameter int MAX_PADDED_WIDTH = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [12:0]           cfg_data,
    output pic_cfg_t              cfg,
    output logic [$clog2(MAX_PADDED_WIDTH + 1)-1:0] padded_width,
    output logic                  restart,
    input  logic                  q_not_full,
    output logic                  q_push,
    output pic_item_t             q_item
);

    localparam int KW   = $clog2(KMAX + 1);
    localparam int PW_W = $clog2(MAX_PADDED_WIDTH + 1);
    localparam int XW   = ((PW_W > 11) ? PW_W : 11) + 1;
    localparam int RW   = 14;

    pic_cfg_t        cfg_reg;
    logic [RW-1:0]   row_reg;
    logic [PW_W-1:0] col_reg;
    logic [RW-1:0]   row_next;
    logic [PW_W-1:0] col_next;

    logic [KW-1:0]   ek;
    logic [KW-1:0]   pad;
    logic [KW-1:0]   off;
    logic [XW-1:0]   w0;
    logic [XW-1:0]   wmax;
    logic [XW-1:0]   weff;
    logic [XW-1:0]   pwx;
    logic [RW-1:0]   h0;
    logic [RW-1:0]   ph;
    logic [XW-1:0]   pcx;
    logic [XW-1:0]   cn;
    logic [RW-1:0]   rn;
    logic            in_row;
    logic            in_col;
    logic            pixel_push;

    assign cfg_ready    = 1'b1;
    assign restart      = cfg_valid && cfg_ready;
    assign cfg          = cfg_reg;
    assign s_tready     = q_not_full;
    assign q_push       = s_tvalid && s_tready;
    assign pixel_push   = q_push && (pic_kind_t'(s_tuser) == KIND_PIXEL);
    assign padded_width = PW_W'(pwx);

    always_comb
    begin
        ek   = (32'(cfg_reg.kernel_size) > KMAX) ? KW'(KMAX) : KW'(cfg_reg.kernel_size);
        pad  = ek & ~KW'(1);
        off  = (ek == '0) ? '0 : ek - 1'b1;
        w0   = (cfg_reg.image_width == '0) ? XW'(1) : XW'(cfg_reg.image_width);
        wmax = XW'(MAX_PADDED_WIDTH) - XW'(pad);
        weff = (w0 > wmax) ? wmax : w0;
        pwx  = weff + XW'(pad);
        h0   = (cfg_reg.image_height == '0) ? RW'(1) : RW'(cfg_reg.image_height);
        ph   = h0 + RW'(pad);
        pcx  = XW'(col_reg);

        in_row = (row_reg >= RW'(off)) && ((row_reg - RW'(off)) < h0);
        in_col = (pcx >= XW'(off)) && ((pcx - XW'(off)) < weff);

        cn       = pcx + 1'b1;
        rn       = row_reg + 1'b1;
        col_next = PW_W'(cn);
        row_next = row_reg;
        if (cn >= pwx)
        begin
            col_next = '0;
            row_next = (rn >= ph) ? '0 : rn;
        end

        q_item.kind       = pic_kind_t'(s_tuser);
        q_item.coef_index = s_tdata[5:0];
        q_item.coef_value = s_tdata[23:6];
        q_item.pixel      = s_tdata[55:24];
        q_item.emit       = in_row && in_col;
        q_item.last       = ((row_reg - RW'(off)) == (h0 - 1'b1))
                            && ((pcx - XW'(off)) == (weff - 1'b1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= 11'd640;
            cfg_reg.image_height  <= 13'd480;
            cfg_reg.kernel_size   <= 3'd3;
            cfg_reg.channel_count <= 3'd3;
            row_reg               <= '0;
            col_reg               <= '0;
        end
        else if (restart)
        begin
            unique case (pic_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data[10:0];
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data[12:0];
                REG_KERNEL_SIZE:   cfg_reg.kernel_size   <= cfg_data[2:0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[2:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (pixel_push)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

FILE: rtl/pic_back.sv
// Back part: coefficient table, line store, window and sum-of-products pipeline.
`timescale 1ns / 1ps

module pic_back
    import pic_pkg::*;
#(
    parameter int KMAX             = 7,
    parameter int MAX_PADDED_WIDTH = 2048,
    parameter int CHANNELS_MAX     = 4,
    parameter int COEF_FRAC_BITS   = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pic_cfg_t         cfg,
    input  logic [$clog2(MAX_PADDED_WIDTH + 1)-1:0] padded_width,
    input  logic             restart,
    input  logic             q_not_empty,
    input  pic_item_t        q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tlast
);

    localparam int KW     = $clog2(KMAX + 1);
    localparam int PW_W   = $clog2(MAX_PADDED_WIDTH + 1);
    localparam int CA_W   = (MAX_PADDED_WIDTH > 1) ? $clog2(MAX_PADDED_WIDTH) : 1;
    localparam int KK     = KMAX * KMAX;
    localparam int CI_W   = (KK > 1) ? $clog2(KK) : 1;
    localparam int LINES  = (KMAX > 1) ? KMAX - 1 : 1;
    localparam int LW     = LINES * PIX_W;
    localparam int PROD_W = CH_W + 1 + COEF_W;
    localparam int ROW_W  = PROD_W + ((KMAX > 1) ? $clog2(KMAX) : 0);
    localparam int TOT_W  = ROW_W + ((KMAX > 1) ? $clog2(KMAX) : 0);
    localparam int T_W    = TOT_W + 1;
    localparam int HALF   = 1 << (COEF_FRAC_BITS - 1);
    localparam int CC_W   = $clog2(CHANNELS_MAX + 1);

    logic signed [COEF_W-1:0] coef_tab_reg [KK];
    logic signed [COEF_W-1:0] tap_reg [KMAX][KMAX];
    logic signed [COEF_W-1:0] tap_next [KMAX][KMAX];
    logic [PIX_W-1:0]         win_reg [KMAX][KMAX];
    logic [PIX_W-1:0]         column [KMAX];
    logic [PIX_W-1:0]         line_rd [LINES];

    logic signed [PROD_W-1:0] prod_reg [CHANNELS_MAX][KMAX][KMAX];
    logic signed [ROW_W-1:0]  row_reg [CHANNELS_MAX][KMAX];
    logic signed [ROW_W-1:0]  row_next [CHANNELS_MAX][KMAX];
    logic signed [TOT_W-1:0]  tot_reg [CHANNELS_MAX];
    logic signed [TOT_W-1:0]  tot_next [CHANNELS_MAX];
    logic [CH_W-1:0]          byte_next [CHANNELS_MAX];
    logic [CH_W-1:0]          out_byte_reg [CH_NUM];

    logic [CA_W-1:0] col_reg;
    logic [PW_W-1:0] col_inc;
    logic            adv;
    logic            s1_valid_reg;
    pic_item_t       s1_item_reg;
    logic [CA_W-1:0] s1_pc_reg;
    logic            s1_pixel;
    logic            s2_emit_reg;
    logic            s2_last_reg;
    logic            s3_emit_reg;
    logic            s3_last_reg;
    logic            s4_emit_reg;
    logic            s4_last_reg;
    logic            s5_emit_reg;
    logic            s5_last_reg;
    logic            out_valid_reg;
    logic            out_last_reg;

    logic            rd_en;
    logic [LW-1:0]   rd_data;
    logic [LW-1:0]   wr_data;
    logic [LW-1:0]   wr_data_reg;
    logic [CA_W-1:0] wr_addr_reg;
    logic            wr_seen_reg;
    logic            byp_hit;

    logic [KW-1:0]   ek;
    logic [CC_W-1:0] cc;

    assign adv      = !out_valid_reg || m_tready;
    assign q_pop    = adv && q_not_empty;
    assign rd_en    = q_pop && (q_head.kind == KIND_PIXEL);
    assign s1_pixel = s1_valid_reg && (s1_item_reg.kind == KIND_PIXEL);
    assign byp_hit  = wr_seen_reg && (wr_addr_reg == s1_pc_reg);
    assign col_inc  = PW_W'(col_reg) + 1'b1;
    assign ek       = (32'(cfg.kernel_size) > KMAX) ? KW'(KMAX) : KW'(cfg.kernel_size);
    assign cc       = (32'(cfg.channel_count) > CHANNELS_MAX) ? CC_W'(CHANNELS_MAX)
                                                              : CC_W'(cfg.channel_count);

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_byte_reg[3], out_byte_reg[2], out_byte_reg[1], out_byte_reg[0]};

    pic_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_PADDED_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (adv && s1_pixel),
        .waddr (s1_pc_reg),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (col_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        for (int i = 0; i < LINES; i++)
        begin
            line_rd[i] = byp_hit ? wr_data_reg[i*PIX_W +: PIX_W] : rd_data[i*PIX_W +: PIX_W];
        end
        column[KMAX-1] = s1_item_reg.pixel;
        for (int i = 0; i < KMAX - 1; i++)
        begin
            column[KMAX-2-i] = line_rd[i];
        end
        wr_data[PIX_W-1:0] = s1_item_reg.pixel;
        for (int i = 1; i < LINES; i++)
        begin
            wr_data[i*PIX_W +: PIX_W] = line_rd[i-1];
        end
    end

    // Tap (i, j) of the window uses coefficient (i - base) * K + (j - base).
    always_comb
    begin
        for (int i = 0; i < KMAX; i++)
        begin
            for (int j = 0; j < KMAX; j++)
            begin
                tap_next[i][j] = '0;
                for (int kk = 1; kk <= KMAX; kk++)
                begin
                    if ((ek == KW'(kk)) && (i >= KMAX - kk) && (j >= KMAX - kk))
                    begin
                        tap_next[i][j] =
                            coef_tab_reg[(i - (KMAX - kk)) * kk + (j - (KMAX - kk))];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < CHANNELS_MAX; ch++)
        begin
            for (int i = 0; i < KMAX; i++)
            begin
                row_next[ch][i] = '0;
                for (int j = 0; j < KMAX; j++)
                begin
                    row_next[ch][i] = row_next[ch][i] + ROW_W'(prod_reg[ch][i][j]);
                end
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < CHANNELS_MAX; ch++)
        begin
            tot_next[ch] = '0;
            for (int i = 0; i < KMAX; i++)
            begin
                tot_next[ch] = tot_next[ch] + TOT_W'(row_reg[ch][i]);
            end
        end
    end

    always_comb
    begin
        logic signed [T_W-1:0] t;
        logic signed [T_W-1:0] q;
        for (int ch = 0; ch < CHANNELS_MAX; ch++)
        begin
            t = T_W'(tot_reg[ch]) + T_W'(HALF);
            q = t >>> COEF_FRAC_BITS;
            if (t < 0 || 32'(ch) >= 32'(cc))
            begin
                byte_next[ch] = '0;
            end
            else if (q > T_W'(255))
            begin
                byte_next[ch] = 8'd255;
            end
            else
            begin
                byte_next[ch] = q[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_emit_reg   <= 1'b0;
            s3_emit_reg   <= 1'b0;
            s4_emit_reg   <= 1'b0;
            s5_emit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            wr_seen_reg   <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                col_reg <= '0;
            end
            else if (rd_en)
            begin
                col_reg <= (col_inc >= padded_width) ? '0 : CA_W'(col_inc);
            end
            if (adv)
            begin
                s1_valid_reg  <= q_pop;
                s2_emit_reg   <= s1_pixel && s1_item_reg.emit;
                s3_emit_reg   <= s2_emit_reg;
                s4_emit_reg   <= s3_emit_reg;
                s5_emit_reg   <= s4_emit_reg;
                out_valid_reg <= s5_emit_reg;
                if (s1_pixel)
                begin
                    wr_seen_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (q_head.kind == KIND_COEF) && (32'(q_head.coef_index) < KK))
        begin
            coef_tab_reg[CI_W'(q_head.coef_index)] <= q_head.coef_value;
        end
        if (adv)
        begin
            s1_item_reg  <= q_head;
            s1_pc_reg    <= col_reg;
            tap_reg      <= tap_next;
            s2_last_reg  <= s1_item_reg.last;
            s3_last_reg  <= s2_last_reg;
            s4_last_reg  <= s3_last_reg;
            s5_last_reg  <= s4_last_reg;
            out_last_reg <= s5_last_reg;
            row_reg      <= row_next;
            tot_reg      <= tot_next;
            for (int ch = 0; ch < CH_NUM; ch++)
            begin
                out_byte_reg[ch] <= (ch < CHANNELS_MAX) ? byte_next[ch] : '0;
            end
            for (int ch = 0; ch < CHANNELS_MAX; ch++)
            begin
                for (int i = 0; i < KMAX; i++)
                begin
                    for (int j = 0; j < KMAX; j++)
                    begin
                        prod_reg[ch][i][j] <=
                            PROD_W'($signed({1'b0, win_reg[i][j][ch*CH_W +: CH_W]})
                                    * tap_reg[i][j]);
                    end
                end
            end
            if (s1_pixel)
            begin
                wr_addr_reg <= s1_pc_reg;
                wr_data_reg <= wr_data;
                for (int i = 0; i < KMAX; i++)
                begin
                    for (int j = 0; j < KMAX - 1; j++)
                    begin
                        win_reg[i][j] <= win_reg[i][j+1];
                    end
                    win_reg[i][KMAX-1] <= column[i];
                end
            end
        end
    end

endmodule

FILE: rtl/padded_image_convolution.sv
// Top level of the K by K convolution over a padded, channel-interleaved image.
//
//   Channel  Direction  Contents
//   s_*      in         coefficient writes and padded pixels, selected by s_tuser
//   m_*      out        rounded, clamped result pixels, m_tlast on the frame's last one
//   cfg_*    in         register writes: width, height, kernel size, channel count
//
// One input transfer is taken every clock while the output is drained; a result follows its pixel
// through the line store read, the window and the product, row sum, total and output registers.
// The line store is one read and one write per pixel, so pixel rate is one per clock while output drains.
// Reset needs no clearing pass; the first result rows only use lines written in the frame.
// A stalled output holds the whole back pipeline; the four-entry queue takes input until it is full.
`timescale 1ns / 1ps

module padded_image_convolution
    import pic_pkg::*;
#(
    parameter int KMAX             = 7,
    parameter int MAX_PADDED_WIDTH = 2048,
    parameter int CHANNELS_MAX     = 4,
    parameter int COEF_FRAC_BITS   = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // coef_index, coef_value, pix_ch0, pix_ch1, pix_ch2, pix_ch3
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_ch0, out_ch1, out_ch2, out_ch3
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int PW_W = $clog2(MAX_PADDED_WIDTH + 1);

    pic_cfg_t        cfg;
    logic [PW_W-1:0] padded_width;
    logic            restart;
    logic            q_not_full;
    logic            q_push;
    pic_item_t       q_item;
    logic            q_pop;
    logic            q_not_empty;
    pic_item_t       q_head;

    pic_front #(
        .KMAX             (KMAX),
        .MAX_PADDED_WIDTH (MAX_PADDED_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .padded_width (padded_width),
        .restart      (restart),
        .q_not_full   (q_not_full),
        .q_push       (q_push),
        .q_item       (q_item)
    );

    pic_queue #(
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head)
    );

    pic_back #(
        .KMAX             (KMAX),
        .MAX_PADDED_WIDTH (MAX_PADDED_WIDTH),
        .CHANNELS_MAX     (CHANNELS_MAX),
        .COEF_FRAC_BITS   (COEF_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .padded_width (padded_width),
        .restart      (restart),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule
